// ----- sv/rpwt_pkg.sv -----
// ----------------------------------------------------------------------------
// rpwt_pkg
// Shared widths, payload types, register codes and fixed-point helpers for the
// camera-to-world pose transform.
// ----------------------------------------------------------------------------
package rpwt_pkg;

  // field formats: rotation Q2.14, position Q16.16
  localparam int ROT_WIDTH   = 16;
  localparam int POS_WIDTH   = 32;
  localparam int ROT_FRAC    = ROT_WIDTH - 2;
  localparam int ROW_BITS    = 3 * ROT_WIDTH;
  localparam int CFG_WIDTH   = (ROW_BITS > POS_WIDTH) ? ROW_BITS : POS_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;

  // internal widths
  localparam int RPROD_WIDTH = 2 * ROT_WIDTH;
  localparam int PPROD_WIDTH = ROT_WIDTH + POS_WIDTH;
  localparam int RRND_WIDTH  = RPROD_WIDTH - ROT_FRAC;
  localparam int PRND_WIDTH  = PPROD_WIDTH - ROT_FRAC;
  localparam int RACC_WIDTH  = RRND_WIDTH + 2;
  localparam int PACC_WIDTH  = PRND_WIDTH + 2;

  localparam int ROT_ONE  = 1 << ROT_FRAC;
  localparam int RND_HALF = 1 << (ROT_FRAC - 1);

  // identity rotation after reset
  localparam logic [ROW_BITS-1:0] ROW0_RESET = ROW_BITS'(ROT_ONE);
  localparam logic [ROW_BITS-1:0] ROW1_RESET = ROW0_RESET << ROT_WIDTH;
  localparam logic [ROW_BITS-1:0] ROW2_RESET = ROW0_RESET << (2 * ROT_WIDTH);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_TRANS_X  = 3'd3,
    CFG_TRANS_Y  = 3'd4,
    CFG_TRANS_Z  = 3'd5
  } cfg_reg_e;

  typedef logic signed [ROT_WIDTH-1:0]   rot_t;
  typedef logic signed [POS_WIDTH-1:0]   pos_t;
  typedef logic signed [RPROD_WIDTH-1:0] rprod_t;
  typedef logic signed [PPROD_WIDTH-1:0] pprod_t;
  typedef logic signed [RRND_WIDTH-1:0]  rrnd_t;
  typedef logic signed [PRND_WIDTH-1:0]  prnd_t;
  typedef logic signed [RACC_WIDTH-1:0]  racc_t;
  typedef logic signed [PACC_WIDTH-1:0]  pacc_t;

  // camera rotation, indexed [row][column]
  typedef rot_t [2:0][2:0] cmat_t;
  typedef pos_t [2:0]      tvec_t;

  typedef struct packed {
    logic signed [ROT_WIDTH-1:0] in_r00;
    logic signed [ROT_WIDTH-1:0] in_r01;
    logic signed [ROT_WIDTH-1:0] in_r02;
    logic signed [ROT_WIDTH-1:0] in_r10;
    logic signed [ROT_WIDTH-1:0] in_r11;
    logic signed [ROT_WIDTH-1:0] in_r12;
    logic signed [ROT_WIDTH-1:0] in_r20;
    logic signed [ROT_WIDTH-1:0] in_r21;
    logic signed [ROT_WIDTH-1:0] in_r22;
    logic signed [POS_WIDTH-1:0] in_px;
    logic signed [POS_WIDTH-1:0] in_py;
    logic signed [POS_WIDTH-1:0] in_pz;
  } pose_in_t;

  typedef struct packed {
    logic signed [ROT_WIDTH-1:0] out_r00;
    logic signed [ROT_WIDTH-1:0] out_r01;
    logic signed [ROT_WIDTH-1:0] out_r02;
    logic signed [ROT_WIDTH-1:0] out_r10;
    logic signed [ROT_WIDTH-1:0] out_r11;
    logic signed [ROT_WIDTH-1:0] out_r12;
    logic signed [ROT_WIDTH-1:0] out_r20;
    logic signed [ROT_WIDTH-1:0] out_r21;
    logic signed [ROT_WIDTH-1:0] out_r22;
    logic signed [POS_WIDTH-1:0] out_px;
    logic signed [POS_WIDTH-1:0] out_py;
    logic signed [POS_WIDTH-1:0] out_pz;
  } pose_out_t;

  // raw products: rot[i][j][k] = C[i][k]*R[k][j], pos[i][k] = C[i][k]*P[k]
  typedef struct packed {
    rprod_t [2:0][2:0][2:0] rot;
    pprod_t [2:0][2:0]      pos;
  } prod_t;

  // products rounded to the output fraction bits
  typedef struct packed {
    rrnd_t [2:0][2:0][2:0] rot;
    prnd_t [2:0][2:0]      pos;
  } rnd_t;

  function automatic rprod_t mul_rot(rot_t a, rot_t b);
    rprod_t ax;
    rprod_t bx;
    ax = RPROD_WIDTH'(a);
    bx = RPROD_WIDTH'(b);
    return ax * bx;
  endfunction

  function automatic pprod_t mul_pos(rot_t a, pos_t b);
    pprod_t ax;
    pprod_t bx;
    ax = PPROD_WIDTH'(a);
    bx = PPROD_WIDTH'(b);
    return ax * bx;
  endfunction

  // add half an LSB, then floor: ties go toward plus infinity
  function automatic rrnd_t rnd_rot(rprod_t p);
    rprod_t t;
    t = p + RPROD_WIDTH'(RND_HALF);
    return t[RPROD_WIDTH-1:ROT_FRAC];
  endfunction

  function automatic prnd_t rnd_pos(pprod_t p);
    pprod_t t;
    t = p + PPROD_WIDTH'(RND_HALF);
    return t[PPROD_WIDTH-1:ROT_FRAC];
  endfunction

  function automatic racc_t sum_rot(rrnd_t a, rrnd_t b, rrnd_t c);
    return RACC_WIDTH'(a) + RACC_WIDTH'(b) + RACC_WIDTH'(c);
  endfunction

  function automatic pacc_t sum_pos(prnd_t a, prnd_t b, prnd_t c, pos_t t);
    return PACC_WIDTH'(a) + PACC_WIDTH'(b) + PACC_WIDTH'(c) + PACC_WIDTH'(t);
  endfunction

  // clamp to the signed range of the field
  function automatic rot_t sat_rot(racc_t v);
    logic ovf;
    ovf = (v[RACC_WIDTH-1:ROT_WIDTH-1] != {(RACC_WIDTH-ROT_WIDTH+1){v[RACC_WIDTH-1]}});
    if (!ovf) begin
      return v[ROT_WIDTH-1:0];
    end
    return v[RACC_WIDTH-1] ? {1'b1, {(ROT_WIDTH-1){1'b0}}} : {1'b0, {(ROT_WIDTH-1){1'b1}}};
  endfunction

  function automatic pos_t sat_pos(pacc_t v);
    logic ovf;
    ovf = (v[PACC_WIDTH-1:POS_WIDTH-1] != {(PACC_WIDTH-POS_WIDTH+1){v[PACC_WIDTH-1]}});
    if (!ovf) begin
      return v[POS_WIDTH-1:0];
    end
    return v[PACC_WIDTH-1] ? {1'b1, {(POS_WIDTH-1){1'b0}}} : {1'b0, {(POS_WIDTH-1){1'b1}}};
  endfunction

endpackage

// ----- sv/rigid_pose_to_world_transform_unit.sv -----
// ----------------------------------------------------------------------------
// rigid_pose_to_world_transform_unit
// Maps a camera-frame pose (rotation R, position P) to world coordinates:
// rotation C*R and position T + C*P, with C and T held in config registers.
//
//   channel   handshake              word / fields
//   --------  ---------------------  ----------------------------------------
//   input     in_valid / in_ready    in_pose   : R (Q2.14), P (Q16.16)
//   output    out_valid / out_ready  out_pose  : C*R, T+C*P, saturated
//   config    cfg_wr_en              cfg_index, cfg_data (no read-back)
//
// Three register stages (multiply, round, sum and saturate); one word per
// cycle is taken in steady state while the output is not stalled, with
// every product formed at once by the 36-entry multiplier array.
// Reset loads the identity rotation and zero translation and empties the
// pipeline. A stall holds every full stage; empty stages still fill, so
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rigid_pose_to_world_transform_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rpwt_pkg::pose_in_t                    in_pose,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rpwt_pkg::pose_out_t                   out_pose,
  input  logic                                  cfg_wr_en,
  input  logic [rpwt_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [rpwt_pkg::CFG_WIDTH-1:0]        cfg_data
);
  import rpwt_pkg::*;

  logic [ROW_BITS-1:0] cam_rot_row0;
  logic [ROW_BITS-1:0] cam_rot_row1;
  logic [ROW_BITS-1:0] cam_rot_row2;
  pos_t                cam_trans_x;
  pos_t                cam_trans_y;
  pos_t                cam_trans_z;

  cmat_t cam_rot;
  tvec_t cam_trans;

  logic  prod_valid;
  logic  prod_ready;
  prod_t prod;
  logic  rnd_valid;
  logic  rnd_ready;
  rnd_t  rnd;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_rot_row0 <= ROW0_RESET;
      cam_rot_row1 <= ROW1_RESET;
      cam_rot_row2 <= ROW2_RESET;
      cam_trans_x  <= '0;
      cam_trans_y  <= '0;
      cam_trans_z  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROT_ROW0: cam_rot_row0 <= cfg_data[ROW_BITS-1:0];
        CFG_ROT_ROW1: cam_rot_row1 <= cfg_data[ROW_BITS-1:0];
        CFG_ROT_ROW2: cam_rot_row2 <= cfg_data[ROW_BITS-1:0];
        CFG_TRANS_X:  cam_trans_x  <= cfg_data[POS_WIDTH-1:0];
        CFG_TRANS_Y:  cam_trans_y  <= cfg_data[POS_WIDTH-1:0];
        CFG_TRANS_Z:  cam_trans_z  <= cfg_data[POS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // rows stack as [row][column], column 0 in the low bits
  assign cam_rot   = {cam_rot_row2, cam_rot_row1, cam_rot_row0};
  assign cam_trans = {cam_trans_z, cam_trans_y, cam_trans_x};

  rpwt_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pose    (in_pose),
    .cam_rot    (cam_rot),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  rpwt_rnd u_rnd (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .rnd_valid  (rnd_valid),
    .rnd_ready  (rnd_ready),
    .rnd        (rnd)
  );

  rpwt_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .rnd_valid  (rnd_valid),
    .rnd_ready  (rnd_ready),
    .rnd        (rnd),
    .cam_trans  (cam_trans),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pose   (out_pose)
  );

endmodule

// ----- sv/rpwt_mul.sv -----
// ----------------------------------------------------------------------------
// rpwt_mul
// First pipeline stage: the multiplier array. Forms every product of the
// camera rotation with the input rotation and position, full precision.
// ----------------------------------------------------------------------------
module rpwt_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpwt_pkg::pose_in_t in_pose,
  input  rpwt_pkg::cmat_t   cam_rot,
  output logic              prod_valid,
  input  logic              prod_ready,
  output rpwt_pkg::prod_t   prod
);
  import rpwt_pkg::*;

  rot_t    rmat [3][3];
  pos_t    pvec [3];
  prod_t   prod_next;
  logic    stage_ready;

  // unpack the input word into matrix form
  always_comb begin
    rmat[0][0] = in_pose.in_r00;
    rmat[0][1] = in_pose.in_r01;
    rmat[0][2] = in_pose.in_r02;
    rmat[1][0] = in_pose.in_r10;
    rmat[1][1] = in_pose.in_r11;
    rmat[1][2] = in_pose.in_r12;
    rmat[2][0] = in_pose.in_r20;
    rmat[2][1] = in_pose.in_r21;
    rmat[2][2] = in_pose.in_r22;
    pvec[0]    = in_pose.in_px;
    pvec[1]    = in_pose.in_py;
    pvec[2]    = in_pose.in_pz;
  end

  // one multiplier per product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_next.rot[i][j][k] = mul_rot(cam_rot[i][k], rmat[k][j]);
        end
        prod_next.pos[i][k] = mul_pos(cam_rot[i][k], pvec[k]);
      end
    end
  end

  // advance when the stage is empty or its word moves on
  assign stage_ready = !prod_valid || prod_ready;
  assign in_ready    = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (stage_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && stage_ready) begin
      prod <= prod_next;
    end
  end

endmodule

// ----- sv/rpwt_rnd.sv -----
// ----------------------------------------------------------------------------
// rpwt_rnd
// Second pipeline stage: rounds each product on its own to the output
// fraction bits (half an LSB added, then floored).
// ----------------------------------------------------------------------------
module rpwt_rnd (
  input  logic            clk,
  input  logic            rst,
  input  logic            prod_valid,
  output logic            prod_ready,
  input  rpwt_pkg::prod_t prod,
  output logic            rnd_valid,
  input  logic            rnd_ready,
  output rpwt_pkg::rnd_t  rnd
);
  import rpwt_pkg::*;

  rnd_t rnd_next;
  logic stage_ready;

  // round every product independently
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          rnd_next.rot[i][j][k] = rnd_rot(prod.rot[i][j][k]);
        end
        rnd_next.pos[i][k] = rnd_pos(prod.pos[i][k]);
      end
    end
  end

  // hold while the next stage is full and stalled
  assign stage_ready = !rnd_valid || rnd_ready;
  assign prod_ready  = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (stage_ready) begin
      rnd_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && stage_ready) begin
      rnd <= rnd_next;
    end
  end

endmodule

// ----- sv/rpwt_acc.sv -----
// ----------------------------------------------------------------------------
// rpwt_acc
// Third pipeline stage and output register: adds the three rounded products
// (and the translation for a position), then saturates to the field range.
// ----------------------------------------------------------------------------
module rpwt_acc (
  input  logic                clk,
  input  logic                rst,
  input  logic                rnd_valid,
  output logic                rnd_ready,
  input  rpwt_pkg::rnd_t      rnd,
  input  rpwt_pkg::tvec_t     cam_trans,
  output logic                out_valid,
  input  logic                out_ready,
  output rpwt_pkg::pose_out_t out_pose
);
  import rpwt_pkg::*;

  rot_t      rot_o [3][3];
  pos_t      pos_o [3];
  pose_out_t out_next;
  logic      stage_ready;

  // sum and clamp each output entry
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_o[i][j] = sat_rot(sum_rot(rnd.rot[i][j][0], rnd.rot[i][j][1],
                                      rnd.rot[i][j][2]));
      end
      pos_o[i] = sat_pos(sum_pos(rnd.pos[i][0], rnd.pos[i][1], rnd.pos[i][2],
                                 cam_trans[i]));
    end
  end

  always_comb begin
    out_next.out_r00 = rot_o[0][0];
    out_next.out_r01 = rot_o[0][1];
    out_next.out_r02 = rot_o[0][2];
    out_next.out_r10 = rot_o[1][0];
    out_next.out_r11 = rot_o[1][1];
    out_next.out_r12 = rot_o[1][2];
    out_next.out_r20 = rot_o[2][0];
    out_next.out_r21 = rot_o[2][1];
    out_next.out_r22 = rot_o[2][2];
    out_next.out_px  = pos_o[0];
    out_next.out_py  = pos_o[1];
    out_next.out_pz  = pos_o[2];
  end

  // output register: hold the word until it is taken
  assign stage_ready = !out_valid || out_ready;
  assign rnd_ready   = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_ready) begin
      out_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_valid && stage_ready) begin
      out_pose <= out_next;
    end
  end

endmodule
